// ===== rtl/djss_pkg.sv =====
package djss_pkg;

    typedef struct packed {
        logic [15:0] profit;
        logic [7:0]  deadline;
        logic        last_job;
    } job_t;

    typedef struct packed {
        logic [23:0] total_profit;
        logic [8:0]  placed_count;
        logic        overflow;
    } result_t;

    localparam logic CFG_SLOT_COUNT    = 1'b0;
    localparam logic CFG_SLOT_CAPACITY = 1'b1;

    localparam logic [6:0] SLOT_COUNT_RESET    = 7'd64;
    localparam logic [4:0] SLOT_CAPACITY_RESET = 5'd1;

    localparam logic [23:0] TOTAL_MAX  = 24'hFFFFFF;
    localparam logic [8:0]  PLACED_MAX = 9'h1FF;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sort_init;
        logic latch_cur;
        logic rd_jm1;
        logic shift_wr;
        logic put_cur;
        logic clr_init;
        logic clr_wr;
        logic place_init;
        logic job_latch;
        logic fill_upd;
        logic slot_dec;
        logic i_inc;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic i_ge_n;
        logic j_zero;
        logic cur_gt;
        logic s_zero;
        logic cap_zero;
        logic fill_lt_cap;
        logic clr_done;
    } stat_t;

endpackage

// ===== rtl/djss_ram.sv =====
module djss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/djss_ctrl.sv =====
module djss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  djss_pkg::stat_t stat,
    output djss_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           result_valid
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_OUTER   = 4'd1;
    localparam logic [3:0] ST_CUR     = 4'd2;
    localparam logic [3:0] ST_RD      = 4'd3;
    localparam logic [3:0] ST_CMP     = 4'd4;
    localparam logic [3:0] ST_PUT     = 4'd5;
    localparam logic [3:0] ST_CLR     = 4'd6;
    localparam logic [3:0] ST_P_OUTER = 4'd7;
    localparam logic [3:0] ST_P_JOB   = 4'd8;
    localparam logic [3:0] ST_P_SLOT  = 4'd9;
    localparam logic [3:0] ST_P_CHK   = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (stat.last)
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_OUTER;
                    end
                end
            end
            ST_OUTER:
            begin
                if (stat.i_ge_n)
                begin
                    cmd.clr_init = 1'b1;
                    state_next   = ST_CLR;
                end
                else
                begin
                    state_next = ST_CUR;
                end
            end
            ST_CUR:
            begin
                cmd.latch_cur = 1'b1;
                state_next    = ST_RD;
            end
            ST_RD:
            begin
                if (stat.j_zero)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    cmd.rd_jm1 = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (stat.cur_gt)
                begin
                    cmd.shift_wr = 1'b1;
                    state_next   = ST_RD;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                cmd.put_cur = 1'b1;
                state_next  = ST_OUTER;
            end
            ST_CLR:
            begin
                if (stat.clr_done)
                begin
                    cmd.place_init = 1'b1;
                    state_next     = ST_P_OUTER;
                end
                else
                begin
                    cmd.clr_wr = 1'b1;
                end
            end
            ST_P_OUTER:
            begin
                if (stat.i_ge_n)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_P_JOB;
                end
            end
            ST_P_JOB:
            begin
                cmd.job_latch = 1'b1;
                state_next    = ST_P_SLOT;
            end
            ST_P_SLOT:
            begin
                if (stat.s_zero || stat.cap_zero)
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_P_OUTER;
                end
                else
                begin
                    state_next = ST_P_CHK;
                end
            end
            ST_P_CHK:
            begin
                if (stat.fill_lt_cap)
                begin
                    cmd.fill_upd = 1'b1;
                    cmd.i_inc    = 1'b1;
                    state_next   = ST_P_OUTER;
                end
                else
                begin
                    cmd.slot_dec = 1'b1;
                    state_next   = ST_P_SLOT;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_DONE);

endmodule

// ===== rtl/djss_dp.sv =====
module djss_dp #(
    parameter int MAX_JOBS     = 256,
    parameter int MAX_SLOTS    = 64,
    parameter int MAX_CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  djss_pkg::job_t    job,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    input  djss_pkg::cmd_t    cmd,
    output djss_pkg::stat_t   stat,
    output djss_pkg::result_t result
);

    localparam int JW  = $clog2(MAX_JOBS + 1);
    localparam int JAW = $clog2(MAX_JOBS);
    localparam int DW  = $clog2(MAX_SLOTS + 1);
    localparam int SAW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW  = $clog2(MAX_CAPACITY + 1);
    localparam int KW  = 16 + DW;

    logic [6:0]    slot_count_reg;
    logic [4:0]    slot_capacity_reg;
    logic [JW-1:0] count_reg;
    logic          dropped_reg;
    logic [JW-1:0] i_reg;
    logic [JW-1:0] j_reg;
    logic [KW-1:0] cur_reg;
    logic [DW-1:0] s_reg;
    logic [15:0]   p_reg;
    logic [23:0]   total_reg;
    logic [8:0]    placed_reg;

    logic [DW-1:0] sc_eff;
    logic [CW-1:0] cap_eff;
    logic [DW-1:0] dl_clamp;
    logic [DW-1:0] key_dl;
    logic [DW-1:0] s_m1;
    logic [JW-1:0] j_m1;
    logic [24:0]   total_sum;

    logic          key_we;
    logic [JAW-1:0] key_waddr;
    logic [KW-1:0] key_wdata;
    logic [JAW-1:0] key_raddr;
    logic [KW-1:0] key_rdata;

    logic          fill_we;
    logic [SAW-1:0] fill_waddr;
    logic [CW-1:0] fill_wdata;
    logic [CW-1:0] fill_rdata;

    // clamp configuration and job deadline to the built limits
    assign sc_eff  = ({25'd0, slot_count_reg} > 32'(MAX_SLOTS)) ?
                     DW'(MAX_SLOTS) : DW'(slot_count_reg);
    assign cap_eff = ({27'd0, slot_capacity_reg} > 32'(MAX_CAPACITY)) ?
                     CW'(MAX_CAPACITY) : CW'(slot_capacity_reg);
    assign dl_clamp = ({24'd0, job.deadline} > 32'(MAX_SLOTS)) ?
                      DW'(MAX_SLOTS) : DW'(job.deadline);

    assign key_dl    = key_rdata[DW-1:0];
    assign s_m1      = s_reg - DW'(1);
    assign j_m1      = j_reg - JW'(1);
    assign total_sum = {1'b0, total_reg} + {9'd0, p_reg};

    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = count_reg[JAW-1:0];
        key_wdata = {job.profit, dl_clamp};
        if (cmd.load && (count_reg != JW'(MAX_JOBS)))
        begin
            key_we = 1'b1;
        end
        else if (cmd.shift_wr)
        begin
            key_we    = 1'b1;
            key_waddr = j_reg[JAW-1:0];
            key_wdata = key_rdata;
        end
        else if (cmd.put_cur)
        begin
            key_we    = 1'b1;
            key_waddr = j_reg[JAW-1:0];
            key_wdata = cur_reg;
        end
    end

    assign key_raddr = cmd.rd_jm1 ? j_m1[JAW-1:0] : i_reg[JAW-1:0];

    assign fill_we    = cmd.clr_wr || cmd.fill_upd;
    assign fill_waddr = cmd.clr_wr ? s_reg[SAW-1:0] : s_m1[SAW-1:0];
    assign fill_wdata = cmd.clr_wr ? '0 : fill_rdata + CW'(1);

    djss_ram #(.WIDTH(KW), .DEPTH(MAX_JOBS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    djss_ram #(.WIDTH(CW), .DEPTH(MAX_SLOTS)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (s_m1[SAW-1:0]),
        .rdata (fill_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg    <= djss_pkg::SLOT_COUNT_RESET;
            slot_capacity_reg <= djss_pkg::SLOT_CAPACITY_RESET;
            count_reg         <= '0;
            dropped_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    djss_pkg::CFG_SLOT_COUNT:    slot_count_reg    <= cfg_data;
                    djss_pkg::CFG_SLOT_CAPACITY: slot_capacity_reg <= cfg_data[4:0];
                    default:                     slot_count_reg    <= slot_count_reg;
                endcase
            end
            if (cmd.load)
            begin
                if (count_reg != JW'(MAX_JOBS))
                begin
                    count_reg <= count_reg + JW'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_init)
        begin
            i_reg <= JW'(1);
        end
        if (cmd.latch_cur)
        begin
            cur_reg <= key_rdata;
            j_reg   <= i_reg;
        end
        if (cmd.shift_wr)
        begin
            j_reg <= j_m1;
        end
        if (cmd.put_cur || cmd.i_inc)
        begin
            i_reg <= i_reg + JW'(1);
        end
        if (cmd.clr_init)
        begin
            s_reg <= '0;
        end
        if (cmd.clr_wr)
        begin
            s_reg <= s_reg + DW'(1);
        end
        if (cmd.place_init)
        begin
            i_reg      <= '0;
            total_reg  <= '0;
            placed_reg <= '0;
        end
        if (cmd.job_latch)
        begin
            p_reg <= key_rdata[KW-1 -: 16];
            s_reg <= (key_dl > sc_eff) ? sc_eff : key_dl;
        end
        if (cmd.slot_dec)
        begin
            s_reg <= s_m1;
        end
        if (cmd.fill_upd)
        begin
            total_reg  <= total_sum[24] ? djss_pkg::TOTAL_MAX : total_sum[23:0];
            if (placed_reg != djss_pkg::PLACED_MAX)
            begin
                placed_reg <= placed_reg + 9'd1;
            end
        end
    end

    assign stat.last        = job.last_job;
    assign stat.i_ge_n      = (i_reg >= count_reg);
    assign stat.j_zero      = (j_reg == '0);
    assign stat.cur_gt      = (cur_reg > key_rdata);
    assign stat.s_zero      = (s_reg == '0);
    assign stat.cap_zero    = (cap_eff == '0);
    assign stat.fill_lt_cap = (fill_rdata < cap_eff);
    assign stat.clr_done    = (s_reg == DW'(MAX_SLOTS));

    assign result.total_profit = total_reg;
    assign result.placed_count = placed_reg;
    assign result.overflow     = dropped_reg;

endmodule

// ===== rtl/deadline_job_slot_scheduler_core.sv =====
// Channel   Ports                          Handshake
// -------   -----------------------------  -------------------------------------
// job in    start, busy, job               word taken when start & !busy
// result    result_valid, result           word shown for one cycle, no stall
// config    cfg_we, cfg_index, cfg_data    register written when cfg_we is high
//
// Loading accepts one job per cycle while idle (one write into the job store;
// a job that arrives with the store full is dropped and flags overflow).
// The job marked last starts a run: insertion sort over the store, then a
// clearing pass over the slot fill memory, then placement, which probes slots
// downward from each job's clamped deadline until it finds one below capacity.
// Reset (rst_n, asynchronous) empties the job set and restores the config registers.
// busy stays high for the whole run; the receiver cannot stall results.
module deadline_job_slot_scheduler_core #(
    parameter int MAX_JOBS     = 256,
    parameter int MAX_SLOTS    = 64,
    parameter int MAX_CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  djss_pkg::job_t    job,
    output logic              result_valid,
    output djss_pkg::result_t result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data
);

    djss_pkg::cmd_t  cmd;
    djss_pkg::stat_t stat;

    // sequence the load, sort, clear and place phases
    djss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // hold job store, slot fill memory, counters and the result word
    djss_dp #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_SLOTS    (MAX_SLOTS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule
